@@ rtl/sha256_stream_hash_unit_assert.svh @@
// Assertion macros for the SHA-256 stream hash unit checkers.
`ifndef SHA256_STREAM_HASH_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASH_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHA256_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 stream hash check failed");

// Consequent checked in the cycle after the antecedent.
`define SHA256_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 stream hash check failed");

`endif

@@ rtl/sha256_pkg.sv @@
// Package: widths, codes, round constants and round functions for the SHA-256 unit.
package sha256_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned NumWords = 8;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned LenW     = 61;

  typedef enum logic [OpW-1:0] {
    OP_ABSORB        = 2'd0,
    OP_ABSORB_FINISH = 2'd1,
    OP_FINISH        = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  // Layout of one block: bytes below limit come from the buffer,
  // pad puts 0x80 at limit, len puts the bit length in the last 8 bytes.
  typedef struct packed {
    logic [6:0] limit;
    logic       pad;
    logic       len;
  } blk_t;

  localparam logic [WordW-1:0] IV [NumWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [WordW-1:0] K [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [WordW-1:0] choose(input logic [WordW-1:0] e,
                                              input logic [WordW-1:0] f,
                                              input logic [WordW-1:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [WordW-1:0] majority(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ rtl/sha256_msg_if.sv @@
// Interface: message byte channel (valid/ready plus operation and byte).
interface sha256_msg_if;
  logic                               valid;
  logic                               ready;
  logic [sha256_pkg::OpW-1:0]         operation;
  logic [sha256_pkg::ByteW-1:0]       data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

@@ rtl/sha256_dig_if.sv @@
// Interface: digest word channel (valid/ready plus word, index and last flag).
interface sha256_dig_if;
  logic                               valid;
  logic                               ready;
  logic [sha256_pkg::WordW-1:0]       digest_word;
  logic [sha256_pkg::IdxW-1:0]        word_index;
  logic                               last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ rtl/sha256_stream_hash_unit.sv @@
// Top level: SHA-256 over a byte stream, one round per cycle on a shared round unit.
// Absorb: a byte that leaves its block open keeps the unit ready; one that completes a 64-byte
// block starts a compression (prefetch, 64 rounds, chain add). A finish runs one or two such
// compressions, then presents 8 digest words, one per cycle while the sink is ready. The round
// unit, one round a cycle, sets the rate; no input transaction is taken while it is busy.
// Reset (async, active low) loads the initial hash and clears counts; the buffer is not cleared.
module sha256_stream_hash_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha256_msg_if.sink    msg_i,
  sha256_dig_if.source  dig_o
);

  localparam logic [5:0] LastRnd  = 6'(sha256_pkg::Rounds - 1);
  localparam logic [2:0] LastWord = 3'(sha256_pkg::NumWords - 1);
  localparam logic [6:0] FullBlk  = 7'd64;
  // Last fill that still leaves room for the 8 length bytes after 0x80.
  localparam logic [6:0] MaxOneBlk = 7'd55;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  sha256_pkg::state_e state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  emit_q;
  logic [5:0]  fill_q;
  logic [sha256_pkg::LenW-1:0] len_q;
  sha256_pkg::blk_t blk_q, nxt_q;
  logic        nxt_vld_q;
  logic        fin_q;

  logic [sha256_pkg::WordW-1:0] h_q [sha256_pkg::NumWords];
  logic [sha256_pkg::WordW-1:0] v_q [sha256_pkg::NumWords];
  // Schedule window: w_q[0] oldest (W[i-16]), w_q[15] newest (W[i-1]).
  logic [sha256_pkg::WordW-1:0] w_q [sha256_pkg::BlkWords];

  // Block buffer: 16 big-endian words, byte writes, registered read.
  logic [sha256_pkg::WordW-1:0] mem [sha256_pkg::BlkWords];
  logic [sha256_pkg::WordW-1:0] rd_q;
  logic [3:0]                   rd_addr;

  // ---------------------------------------------------------------------------
  // Input decode and block planning
  // ---------------------------------------------------------------------------
  logic             msg_xfer, dig_xfer;
  logic             is_abs, is_fin, start;
  logic [6:0]       fill_sum;
  sha256_pkg::blk_t blk_new, nxt_new;
  logic             nxt_vld_new;

  assign msg_xfer = msg_i.valid && msg_i.ready;
  assign dig_xfer = dig_o.valid && dig_o.ready;

  always_comb begin
    is_abs = 1'b0;
    is_fin = 1'b0;
    case (sha256_pkg::op_e'(msg_i.operation))
      sha256_pkg::OP_ABSORB: begin
        is_abs = 1'b1;
      end
      sha256_pkg::OP_ABSORB_FINISH: begin
        is_abs = 1'b1;
        is_fin = 1'b1;
      end
      sha256_pkg::OP_FINISH: begin
        is_fin = 1'b1;
      end
      default: begin
        // unused code: transaction taken, nothing happens
      end
    endcase
  end

  assign fill_sum = {1'b0, fill_q} + {6'd0, is_abs};

  // A full buffer compresses as is; a finish then needs a pad-only block.
  // A finish with 56..63 bytes pending needs a second block for the length.
  always_comb begin
    blk_new     = '{limit: fill_sum, pad: 1'b1, len: 1'b1};
    nxt_new     = '{limit: 7'd0, pad: 1'b0, len: 1'b1};
    nxt_vld_new = 1'b0;
    start       = 1'b0;
    if (fill_sum[6]) begin
      blk_new     = '{limit: FullBlk, pad: 1'b0, len: 1'b0};
      nxt_new     = '{limit: 7'd0, pad: 1'b1, len: 1'b1};
      nxt_vld_new = is_fin;
      start       = 1'b1;
    end else if (is_fin) begin
      start = 1'b1;
      if (fill_sum > MaxOneBlk) begin
        blk_new     = '{limit: fill_sum, pad: 1'b1, len: 1'b0};
        nxt_vld_new = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (msg_xfer && start) state_d = sha256_pkg::ST_PREP;
      end
      sha256_pkg::ST_PREP: begin
        state_d = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd_q == LastRnd) state_d = sha256_pkg::ST_ADD;
      end
      sha256_pkg::ST_ADD: begin
        if (nxt_vld_q)  state_d = sha256_pkg::ST_PREP;
        else if (fin_q) state_d = sha256_pkg::ST_EMIT;
        else            state_d = sha256_pkg::ST_IDLE;
      end
      sha256_pkg::ST_EMIT: begin
        if (dig_xfer && emit_q == LastWord) state_d = sha256_pkg::ST_IDLE;
      end
      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rnd_d   = rnd_q;
    rd_addr = rnd_q[3:0] + 4'd1;
    case (state_q)
      sha256_pkg::ST_PREP: begin
        rnd_d   = 6'd0;
        rd_addr = 4'd0;
      end
      sha256_pkg::ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    msg_i.ready       = (state_q == sha256_pkg::ST_IDLE);
    dig_o.valid       = (state_q == sha256_pkg::ST_EMIT);
    dig_o.digest_word = h_q[emit_q];
    dig_o.word_index  = emit_q;
    dig_o.last_word   = (emit_q == LastWord);
  end

  // ---------------------------------------------------------------------------
  // Control registers and chaining value
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha256_pkg::ST_IDLE;
      rnd_q     <= '0;
      emit_q    <= '0;
      fill_q    <= '0;
      len_q     <= '0;
      blk_q     <= '0;
      nxt_q     <= '0;
      nxt_vld_q <= 1'b0;
      fin_q     <= 1'b0;
      for (int k = 0; k < sha256_pkg::NumWords; k++) h_q[k] <= sha256_pkg::IV[k];
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      if (msg_xfer) begin
        if (is_abs) begin
          fill_q <= fill_sum[5:0];
          len_q  <= len_q + {{(sha256_pkg::LenW-1){1'b0}}, 1'b1};
        end
        if (start) begin
          blk_q     <= blk_new;
          nxt_q     <= nxt_new;
          nxt_vld_q <= nxt_vld_new;
          fin_q     <= is_fin;
        end
      end
      if (state_q == sha256_pkg::ST_ADD) begin
        for (int k = 0; k < sha256_pkg::NumWords; k++) h_q[k] <= h_q[k] + v_q[k];
        if (nxt_vld_q) begin
          blk_q     <= nxt_q;
          nxt_vld_q <= 1'b0;
        end
      end
      if (dig_xfer) begin
        emit_q <= emit_q + 3'd1;
        if (emit_q == LastWord) begin
          // message done: back to the initial state
          fill_q <= '0;
          len_q  <= '0;
          fin_q  <= 1'b0;
          for (int k = 0; k < sha256_pkg::NumWords; k++) h_q[k] <= sha256_pkg::IV[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Block buffer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (msg_xfer && is_abs) begin
      for (int j = 0; j < 4; j++) begin
        if (fill_q[1:0] == 2'(3 - j)) mem[fill_q[5:2]][8*j +: 8] <= msg_i.data_byte;
      end
    end
    rd_q <= mem[rd_addr];
  end

  // Message word for rounds 0..15: buffer bytes, 0x80, zeros or length bytes.
  logic [63:0]                  len_bits;
  logic [sha256_pkg::WordW-1:0] len_word, blk_word;
  logic [6:0]                   pos;

  assign len_bits = {len_q, 3'b000};
  assign len_word = rnd_q[0] ? len_bits[31:0] : len_bits[63:32];

  always_comb begin
    blk_word = '0;
    pos      = '0;
    for (int j = 0; j < 4; j++) begin
      pos = {1'b0, rnd_q[3:0], 2'(j)};
      if (pos < blk_q.limit) begin
        blk_word[8*(3-j) +: 8] = rd_q[8*(3-j) +: 8];
      end else if (blk_q.pad && pos == blk_q.limit) begin
        blk_word[8*(3-j) +: 8] = 8'h80;
      end else if (blk_q.len && rnd_q[3:1] == 3'b111) begin
        blk_word[8*(3-j) +: 8] = len_word[8*(3-j) +: 8];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Round unit and schedule
  // ---------------------------------------------------------------------------
  logic [sha256_pkg::WordW-1:0] w_new, w_cur, t1, t2;

  assign w_new = sha256_pkg::ssig1(w_q[14]) + w_q[9] + sha256_pkg::ssig0(w_q[1]) + w_q[0];
  assign w_cur = (rnd_q[5:4] == 2'b00) ? blk_word : w_new;
  assign t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) +
              sha256_pkg::choose(v_q[4], v_q[5], v_q[6]) + sha256_pkg::K[rnd_q] + w_cur;
  assign t2 = sha256_pkg::bsig0(v_q[0]) + sha256_pkg::majority(v_q[0], v_q[1], v_q[2]);

  always_ff @(posedge clk_i) begin
    if (state_q == sha256_pkg::ST_PREP) begin
      for (int k = 0; k < sha256_pkg::NumWords; k++) v_q[k] <= h_q[k];
    end
    if (state_q == sha256_pkg::ST_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int k = 0; k < sha256_pkg::BlkWords - 1; k++) w_q[k] <= w_q[k+1];
      w_q[sha256_pkg::BlkWords-1] <= w_cur;
    end
  end

endmodule

@@ rtl/sha256_stream_hash_unit_chk.sv @@
// Checker: port-level properties of the SHA-256 stream hash unit, bound to the top level.
`include "sha256_stream_hash_unit_assert.svh"

module sha256_stream_hash_unit_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        msg_ready_i,
  input logic        dig_valid_i,
  input logic        dig_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i
);

  // input is never taken while a digest is on offer
  `SHA256_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, dig_valid_i, !msg_ready_i)
  // last flag marks exactly the eighth word
  `SHA256_ASSERT_SAME(a_last_idx, clk_i, rst_ni, dig_valid_i, last_word_i == (word_index_i == 3'd7))
  // words follow in order without gaps
  `SHA256_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, dig_valid_i && dig_ready_i && !last_word_i, dig_valid_i && word_index_i == $past(word_index_i) + 3'd1)
  // after the last word the unit takes input again
  `SHA256_ASSERT_NEXT(a_back_idle, clk_i, rst_ni, dig_valid_i && dig_ready_i && last_word_i, msg_ready_i && !dig_valid_i)
  // a stalled word holds
  `SHA256_ASSERT_NEXT(a_dig_hold, clk_i, rst_ni, dig_valid_i && !dig_ready_i, dig_valid_i && $stable(digest_word_i) && $stable(word_index_i))

endmodule

bind sha256_stream_hash_unit sha256_stream_hash_unit_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .msg_ready_i   (msg_i.ready),
  .dig_valid_i   (dig_o.valid),
  .dig_ready_i   (dig_o.ready),
  .digest_word_i (dig_o.digest_word),
  .word_index_i  (dig_o.word_index),
  .last_word_i   (dig_o.last_word)
);

@@ tb/testbench.sv @@
// Testbench for the SHA-256 stream hash unit: scoreboard against a behavioral SHA-256.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  // Operation code 3 has no meaning; the unit must swallow it without effect.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned TOTAL_ITEMS  = 410;
  // One finish can take two compressions before its first word.
  localparam int unsigned DRAIN_CYCLES = 200;
  // Covers the long receiver hold-off plus a double compression, several times over.
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 400;

  localparam logic [WordW-1:0] HASH_INIT [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [WordW-1:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  typedef struct {
    logic [WordW-1:0] value;
    logic [IdxW-1:0]  position;
    logic             is_last;
  } digest_entry_t;

  logic clk_i;
  logic rst_ni;

  sha256_msg_if msg_if ();
  sha256_dig_if dig_if ();

  sha256_stream_hash_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  // Hash state mirrored on the testbench side, advanced at each accepted transaction.
  logic [WordW-1:0] hash_state [8];
  logic [ByteW-1:0] block_bytes [64];
  int unsigned      fill_level;
  logic [LenW-1:0]  byte_count;   // wraps like the unit's 61-bit length counter

  // Digest words owed by the unit, oldest first.
  digest_entry_t digest_words_due [$];

  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned idle_cycles;

  // Knobs shared by the test tasks and the receiver process.
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_off_len;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Behavioral SHA-256
  // ---------------------------------------------------------------------------
  function automatic logic [WordW-1:0] ror32(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [WordW-1:0] w [16];
    logic [WordW-1:0] a, b, c, d, e, f, g, h;
    logic [WordW-1:0] t1, t2, s0, s1, w2, w15;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        // rolling 16-entry message schedule
        w2  = w[(r - 2) & 15];
        w15 = w[(r - 15) & 15];
        s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
        s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
        w[r & 15] = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
      end
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[r] + w[r & 15];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void hash_restart();
    foreach (hash_state[i]) hash_state[i] = HASH_INIT[i];
    fill_level = 0;
    byte_count = '0;
  endfunction

  // Advance the hash by one transaction; a finish queues the eight digest words.
  function automatic void hash_model_step(input logic [OpW-1:0] op, input logic [ByteW-1:0] data);
    logic [63:0]   bit_len;
    int unsigned   pos;
    digest_entry_t entry;
    if (op == OP_UNUSED) return;
    if (op == OP_ABSORB || op == OP_ABSORB_FINISH) begin
      block_bytes[fill_level] = data;
      byte_count = byte_count + 1'b1;
      fill_level = (fill_level + 1) % 64;
      if (fill_level == 0) compress_block();
    end
    if (op == OP_ABSORB) return;
    // Padding: 0x80, zeros, 64-bit bit length; spills into a second block past 55 bytes.
    pos = fill_level;
    block_bytes[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int unsigned i = pos; i < 64; i++) block_bytes[i] = 8'h00;
      compress_block();
      pos = 0;
    end
    for (int unsigned i = pos; i < 56; i++) block_bytes[i] = 8'h00;
    bit_len = {byte_count, 3'b000};
    for (int i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      entry.value    = hash_state[i];
      entry.position = IdxW'(i);
      entry.is_last  = (i == 7);
      digest_words_due = {digest_words_due, entry};
    end
    hash_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Mostly back to back, sometimes short gaps, rarely long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction at the falling edge, hold it until accepted, then sometimes idle a while.
  task automatic send_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] data);
    int unsigned gap;
    msg_if.valid     <= 1'b1;
    msg_if.operation <= op;
    msg_if.data_byte <= data;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    hash_model_step(op, data);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk_i);
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // One message of len bytes, closed either on its last byte or by a bare finish.
  // Unused-code transactions are sprinkled in as noise.
  task automatic send_message(input int unsigned len, input bit end_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, ByteW'($urandom));
      if (end_on_byte && i == len - 1) send_item(OP_ABSORB_FINISH, ByteW'($urandom));
      else send_item(OP_ABSORB, ByteW'($urandom));
    end
    if (!end_on_byte || len == 0) send_item(OP_FINISH, ByteW'($urandom));
  endtask

  // Sender holds off until every owed digest word has come out.
  task automatic wait_for_digests();
    msg_if.valid <= 1'b0;
    @(negedge clk_i);
    while (digest_words_due.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: ready changes at the falling edge only
  // ---------------------------------------------------------------------------
  initial begin : digest_receiver
    int unsigned stall;
    stall = 0;
    dig_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len > 0) begin
        stall = hold_off_len;
        hold_off_len = 0;
      end else if (stall == 0 && rx_idle_en) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        dig_if.ready <= 1'b0;
        stall--;
      end else begin
        dig_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: compare each digest transaction with the oldest owed word
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    digest_entry_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (digest_words_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: digest word with none owed, expected nothing, actual %h idx %0d last %b",
                 $time, dig_if.digest_word, dig_if.word_index, dig_if.last_word);
      end else begin
        want = digest_words_due.pop_front();
        check_field("digest_word", want.value, dig_if.digest_word);
        check_field("word_index", WordW'(want.position), WordW'(dig_if.word_index));
        check_field("last_word", WordW'(want.is_last), WordW'(dig_if.last_word));
      end
    end
  end

  // Watchdog: too long without any transaction on either side means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAIL sha256_stream_hash_unit");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty message, "abc", single-byte extremes, ignored byte on a bare finish,
  // and the unused code both inside a message and on its own.
  task automatic test_known_digests();
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB_FINISH, 8'h63);
    send_item(OP_ABSORB_FINISH, 8'h00);
    send_item(OP_ABSORB_FINISH, 8'hFF);
    send_item(OP_ABSORB, 8'hA5);
    send_item(OP_FINISH, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_FINISH, 8'h5A);
    wait_for_digests();
  endtask

  // Receiver stalls for a long stretch while the sender keeps going, so the
  // unit sits on a finished digest and has to hold off new bytes.
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    hold_off_len = LONG_HOLD;
    repeat (3) send_message($urandom_range(1, 6), 1'b1);
    tx_idle_en = 1'b1;
    wait_for_digests();
  endtask

  // No idling on either side: exact-fit padding and a second pad block.
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(2, 1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_for_digests();
  endtask

  // Random messages, lengths biased toward the padding boundaries.
  task automatic test_random_messages();
    int unsigned roll;
    int unsigned len;
    while (items_sent < TOTAL_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        len = $urandom_range(0, 15);
      end else if (roll < 85) begin
        case ($urandom_range(0, 5))
          0:       len = 54;
          1:       len = 55;
          2:       len = 56;
          3:       len = 57;
          4:       len = 63;
          default: len = 64;
        endcase
      end else begin
        len = $urandom_range(16, 130);
      end
      send_message(len, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) wait_for_digests();
    end
    wait_for_digests();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    msg_if.valid     = 1'b0;
    msg_if.operation = OP_ABSORB;
    msg_if.data_byte = '0;
    items_sent       = 0;
    mismatch_count   = 0;
    idle_cycles      = 0;
    tx_idle_en       = 1'b1;
    rx_idle_en       = 1'b1;
    hold_off_len     = 0;
    foreach (block_bytes[i]) block_bytes[i] = 8'h00;
    hash_restart();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_known_digests();
    test_output_backpressure();
    test_full_rate();
    test_random_messages();

    // Anything the unit emits beyond what is owed shows up here.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && digest_words_due.size() == 0) begin
      $display("PASS sha256_stream_hash_unit");
    end else begin
      $display("FAIL sha256_stream_hash_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_msg_if.sv
rtl/sha256_dig_if.sv
rtl/sha256_stream_hash_unit.sv
rtl/sha256_stream_hash_unit_chk.sv
tb/testbench.sv
